@@ rtl/assert_macros.svh @@
// Assertion macros shared by the date text converter RTL.
// No dependencies; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DTIF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define DTIF_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define DTIF_ASSERT(lbl, clk, rst_n, prop, msg)

`define DTIF_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ rtl/dtif_pkg.sv @@
// Types, constants and decode helpers for the date text to ISO fields block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dtif_pkg;

  localparam int LINE_CHARS_DEF = 12;
  localparam int SNAP_CHARS     = 12;   // positions the layouts ever look at
  localparam int COUNT_W        = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam int QDEPTH         = 2;
  localparam logic [6:0] PIVOT_RESET = 7'd50;

  localparam logic [13:0] YEAR_BASE_OLD = 14'd1900;
  localparam logic [13:0] YEAR_BASE_NEW = 14'd2000;
  localparam logic [3:0]  SHORT_LEN     = 4'd10;
  localparam logic [3:0]  LONG_LEN      = 4'd12;
  localparam logic [6:0]  MONTH_MAX     = 7'd12;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  localparam logic [2:0] FMT_NONE  = 3'd0;
  localparam logic [2:0] FMT_DASH  = 3'd1;
  localparam logic [2:0] FMT_SLASH = 3'd2;
  localparam logic [2:0] FMT_SHARP = 3'd3;
  localparam logic [2:0] FMT_STAR  = 3'd4;
  localparam logic [2:0] FMT_SHORT = 3'd5;
  localparam logic [2:0] FMT_LONG  = 3'd6;

  typedef struct packed {
    logic [7:0] text_char;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [13:0] year_value;
    logic [3:0]  month_value;
    logic [6:0]  day_value;
    logic [2:0]  format_code;
    logic        fields_valid;
  } out_t;

  // One finished line: positions past the count already read as zero.
  typedef struct packed {
    logic [SNAP_CHARS-1:0][7:0] chars;
    logic [COUNT_W-1:0]         count;
  } line_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h30;
    return is_digit(c) ? d[3:0] : 4'd0;
  endfunction

  function automatic logic [6:0] two_digits(input logic [3:0] a, input logic [3:0] b);
    return 7'(a) * 7'd10 + 7'(b);
  endfunction

  function automatic logic [13:0] four_digits(input logic [3:0] a, input logic [3:0] b,
                                              input logic [3:0] c, input logic [3:0] d);
    return 14'(a) * 14'd1000 + 14'(b) * 14'd100 + 14'(c) * 14'd10 + 14'(d);
  endfunction

  function automatic logic [3:0] month_lookup(input logic [23:0] name);
    logic [3:0] m;
    case (name)
      "Jan": m = 4'd1;
      "Feb": m = 4'd2;
      "Mar": m = 4'd3;
      "Apr": m = 4'd4;
      "May": m = 4'd5;
      "Jun": m = 4'd6;
      "Jul": m = 4'd7;
      "Aug": m = 4'd8;
      "Sep": m = 4'd9;
      "Oct": m = 4'd10;
      "Nov": m = 4'd11;
      "Dec": m = 4'd12;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/dtif_front.sv @@
// Front end: accepts characters, fills the line buffer and keeps the count.
// Depends on dtif_pkg; on the last character it pushes a line snapshot.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtif_front
  import dtif_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_t     in_data,
  input  q_stat_t q_stat,
  output logic    push,
  output line_t   push_line
);

  localparam int IDX_W = $clog2(LINE_CHARS);
  localparam logic [COUNT_W:0] LINE_LIM = (COUNT_W + 1)'(LINE_CHARS);

  logic [LINE_CHARS-1:0][7:0] buf_r;
  logic [COUNT_W-1:0]         count_r, count_nxt, count_inc;
  logic                       accept, wr_en;

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign wr_en     = ({1'b0, count_r} < LINE_LIM) && (count_r != COUNT_MAX);
  assign count_inc = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 4'd1;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = in_data.line_end ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      buf_r[count_r[IDX_W-1:0]] <= in_data.text_char;
    end
  end

  // Snapshot includes the character of this transfer; unread positions go to zero.
  always_comb begin
    logic [7:0] ch;
    push_line.count = count_inc;
    for (int p = 0; p < SNAP_CHARS; p++) begin
      ch = (wr_en && count_r == COUNT_W'(p)) ? in_data.text_char : buf_r[p];
      push_line.chars[p] = (COUNT_W'(p) < count_inc) ? ch : 8'h00;
    end
  end

  assign push = accept && in_data.line_end;

  `DTIF_ASSERT(a_count_clear, clk, rst_n, push |=> count_r == '0, "count not cleared after line")

endmodule

@@ rtl/dtif_fifo.sv @@
// Short line queue between the front end and the decode back end.
// Depends on dtif_pkg for the line type and depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtif_fifo
  import dtif_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  line_t   push_line,
  input  logic    pop,
  output line_t   head_line,
  output q_stat_t q_stat
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [PTR_W:0] DEPTH_V = (PTR_W + 1)'(QDEPTH);

  line_t            mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == DEPTH_V);
  assign q_stat.empty = (count_r == '0);
  assign head_line    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_line;
    end
  end

  `DTIF_NEVER(a_push_full, clk, rst_n, push && q_stat.full, "push into full queue")
  `DTIF_NEVER(a_pop_empty, clk, rst_n, pop && q_stat.empty, "pop from empty queue")

endmodule

@@ rtl/dtif_back.sv @@
// Back end: picks the layout of a queued line, parses the fields, holds the result.
// Depends on dtif_pkg for types, character constants and digit helpers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtif_back
  import dtif_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [6:0] pivot,
  input  q_stat_t    q_stat,
  input  line_t      head_line,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  logic  out_valid_r, out_valid_nxt;
  out_t  out_r, res;

  function automatic logic [13:0] window(input logic [6:0] yy, input logic [6:0] pv);
    return ((yy >= pv) ? YEAR_BASE_OLD : YEAR_BASE_NEW) + 14'(yy);
  endfunction

  always_comb begin
    logic [SNAP_CHARS-1:0][3:0] d;
    logic [SNAP_CHARS-1:0]      ok;
    logic [6:0]                 mnum;
    logic [3:0]                 mword;
    logic [3:0]                 len;
    len = head_line.count;
    for (int p = 0; p < SNAP_CHARS; p++) begin
      d[p]  = digit_val(head_line.chars[p]);
      ok[p] = is_digit(head_line.chars[p]);
    end
    mword = month_lookup({head_line.chars[0], head_line.chars[1], head_line.chars[2]});
    mnum  = 7'd0;
    res   = '0;
    if (head_line.chars[4] == CH_DASH) begin
      mnum             = two_digits(d[5], d[6]);
      res.format_code  = FMT_DASH;
      res.year_value   = four_digits(d[0], d[1], d[2], d[3]);
      res.day_value    = two_digits(d[8], d[9]);
      res.fields_valid = &{ok[0], ok[1], ok[2], ok[3], ok[5], ok[6], ok[8], ok[9]};
    end else if (head_line.chars[2] == CH_SLASH) begin
      mnum             = two_digits(d[0], d[1]);
      res.format_code  = FMT_SLASH;
      res.day_value    = two_digits(d[3], d[4]);
      res.year_value   = window(two_digits(d[6], d[7]), pivot);
      res.fields_valid = &{ok[0], ok[1], ok[3], ok[4], ok[6], ok[7]};
    end else if (head_line.chars[2] == CH_SHARP) begin
      mnum             = two_digits(d[0], d[1]);
      res.format_code  = FMT_SHARP;
      res.year_value   = window(two_digits(d[3], d[4]), pivot);
      res.day_value    = two_digits(d[6], d[7]);
      res.fields_valid = &{ok[0], ok[1], ok[3], ok[4], ok[6], ok[7]};
    end else if (head_line.chars[2] == CH_STAR) begin
      mnum             = two_digits(d[3], d[4]);
      res.format_code  = FMT_STAR;
      res.day_value    = two_digits(d[0], d[1]);
      res.year_value   = four_digits(d[6], d[7], d[8], d[9]);
      res.fields_valid = &{ok[0], ok[1], ok[3], ok[4], ok[6], ok[7], ok[8], ok[9]};
    end else if (head_line.chars[6] == CH_COMMA && len == SHORT_LEN) begin
      res.format_code  = FMT_SHORT;
      res.month_value  = mword;
      res.day_value    = two_digits(d[4], d[5]);
      res.year_value   = window(two_digits(d[8], d[9]), pivot);
      res.fields_valid = &{ok[4], ok[5], ok[8], ok[9]} && (mword != 4'd0);
    end else if (head_line.chars[6] == CH_COMMA && len == LONG_LEN) begin
      res.format_code  = FMT_LONG;
      res.month_value  = mword;
      res.day_value    = two_digits(d[4], d[5]);
      res.year_value   = four_digits(d[8], d[9], d[10], d[11]);
      res.fields_valid = &{ok[4], ok[5], ok[8], ok[9], ok[10], ok[11]} && (mword != 4'd0);
    end
    // numeric layouts: month above twelve reads as zero and flags the line
    if (res.format_code == FMT_DASH || res.format_code == FMT_SLASH ||
        res.format_code == FMT_SHARP || res.format_code == FMT_STAR) begin
      if (mnum > MONTH_MAX) begin
        res.month_value  = 4'd0;
        res.fields_valid = 1'b0;
      end else begin
        res.month_value = mnum[3:0];
      end
    end
  end

  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `DTIF_ASSERT(a_none_zero, clk, rst_n, out_valid_r && out_r.format_code == FMT_NONE |-> out_r == '0, "unmatched line with nonzero fields")
  `DTIF_ASSERT(a_month_range, clk, rst_n, out_valid_r |-> out_r.month_value <= 4'd12, "month out of range")
  `DTIF_ASSERT(a_pop_load, clk, rst_n, pop |=> out_valid_r, "popped line not presented")

endmodule

@@ rtl/date_text_to_iso_fields_core.sv @@
// Date text to ISO fields: one character transfer per cycle, one result per line.
// Each line is registered in the queue, then its decoded fields in the output register.
// The front end takes a character every cycle unless the two-line queue to decode is full;
// decode retires one line per cycle unless the output stalls, so the queue fills only then.
// Synchronous active-low reset clears the count, queue and output valid; pivot resets to 50.
`timescale 1ns / 1ps

module date_text_to_iso_fields_core
  import dtif_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic [6:0] pivot_r;
  logic       push, pop;
  line_t      push_line, head_line;
  q_stat_t    q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r <= PIVOT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pivot_r <= cfg_data;
    end
  end

  dtif_front #(
    .LINE_CHARS(LINE_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_line(push_line)
  );

  dtif_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_line(push_line),
    .pop      (pop),
    .head_line(head_line),
    .q_stat   (q_stat)
  );

  dtif_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pivot    (pivot_r),
    .q_stat   (q_stat),
    .head_line(head_line),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
